FILE: design/csfq_pkg.sv
// Shared types and constants for the counting semaphore with FIFO wait queue.
// Holds the operation, result and error codes and the count unit's structs.
// Depends on nothing; all design files but csfq_ram refer to it by scoped names.
package csfq_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;
  localparam int COUNT_W            = 16;
  localparam int CFG_W              = 15;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_WAIT   = 2'd0,
    KIND_SIGNAL = 2'd1,
    KIND_CLOSE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EV_PROCEED  = 2'd0,
    EV_BLOCKED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_NONE     = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_QUEUE_FULL = 2'd1,
    ERR_SATURATED  = 2'd2
  } err_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] operand;
    logic                      inc;
  } alu_req_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] result;
    logic                      at_min;
    logic                      at_max;
    logic                      a_nonneg;
    logic                      a_le_zero;
    logic                      res_nonneg;
    logic                      res_le_zero;
  } alu_rsp_t;

endpackage

FILE: design/counting_semaphore_fifo_queue_top.sv
// Counting semaphore with a FIFO queue of blocked thread ids.
//
// Input channel (in_valid / in_stall, kind, thread_id): an item is taken at a
// rising edge with in_valid high and in_stall low. kind selects wait, signal
// or close; thread_id names the caller and is queued when a wait blocks.
// Output channel (out_valid / out_stall): each result item carries event_res,
// released_id, available, error and last; last marks the final result of an
// input item. Every input item gives at least one result.
// Each item is first accepted; a wait, a signal or the unused kind then gives
// its single result as it updates the count and the ring. A close releases
// the queued threads in order, one release per cycle while the receiver does
// not stall, or gives one result with no release when the queue is empty.
// The pace is set by the single count unit and the ring RAM's one read port.
// When the receiver stalls, the result stays in the output register and the
// sequencer holds; in_stall stays high until the last result of the item has
// entered the output register, and a following item then waits in the
// sequencer while that result is still stalled.
// Reset (rst, synchronous) empties the queue and sets the count to zero. A
// write on cfg_wr_en loads the count with cfg_wr_data and empties the queue;
// the user must issue it only while idle; the block does not enforce this.
module counting_semaphore_fifo_queue_top #(
  parameter int QUEUE_DEPTH    = csfq_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csfq_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [csfq_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 kind,
  input  logic [THREAD_ID_BITS-1:0]  thread_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 event_res,
  output logic [THREAD_ID_BITS-1:0]  released_id,
  output logic                       available,
  output logic [1:0]                 error,
  output logic                       last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  // Ring RAM connections between the sequencer and the storage.
  logic                      ram_wr_en;
  logic [PTR_W-1:0]          ram_wr_addr;
  logic [THREAD_ID_BITS-1:0] ram_wr_data;
  logic [PTR_W-1:0]          ram_rd_addr;
  logic [THREAD_ID_BITS-1:0] ram_rd_data;

  // The sequencer holds the count, the ring pointers and the result register.
  csfq_seq #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .thread_id   (thread_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .released_id (released_id),
    .available   (available),
    .error       (error),
    .last        (last),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Storage for the blocked thread ids; read data is used only for written entries.
  csfq_ram #(
    .WIDTH (THREAD_ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

FILE: design/csfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the ring of blocked thread ids; no package dependency.
module csfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/csfq_alu.sv
// Shared count unit: one increment or decrement of the semaphore count with
// the limit and sign compares the sequencer decides on. Uses csfq_pkg.
module csfq_alu (
  input  csfq_pkg::alu_req_t req,
  output csfq_pkg::alu_rsp_t rsp
);

  logic signed [csfq_pkg::COUNT_W-1:0] sum;

  assign sum = req.inc ? req.operand + csfq_pkg::COUNT_W'(1)
                       : req.operand - csfq_pkg::COUNT_W'(1);

  always_comb begin
    rsp.result      = sum;
    rsp.at_min      = (req.operand == csfq_pkg::COUNT_MIN);
    rsp.at_max      = (req.operand == csfq_pkg::COUNT_MAX);
    rsp.a_nonneg    = !req.operand[csfq_pkg::COUNT_W-1];
    rsp.a_le_zero   = req.operand[csfq_pkg::COUNT_W-1] || (req.operand == '0);
    rsp.res_nonneg  = !sum[csfq_pkg::COUNT_W-1];
    rsp.res_le_zero = sum[csfq_pkg::COUNT_W-1] || (sum == '0);
  end

endmodule

FILE: design/csfq_seq.sv
// Sequencer of the semaphore: count, ring pointers, fill and the result register.
// Uses csfq_pkg and the shared count unit csfq_alu; drives the ring RAM ports.
module csfq_seq #(
  parameter int QUEUE_DEPTH    = csfq_pkg::QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = csfq_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [csfq_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [THREAD_ID_BITS-1:0]      thread_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     event_res,
  output logic [THREAD_ID_BITS-1:0]      released_id,
  output logic                           available,
  output logic [1:0]                     error,
  output logic                           last,
  output logic                           ram_wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_wr_addr,
  output logic [THREAD_ID_BITS-1:0]      ram_wr_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_rd_addr,
  input  logic [THREAD_ID_BITS-1:0]      ram_rd_data
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [0:0] {ST_IDLE, ST_EXEC} state_t;

  state_t                              state;
  csfq_pkg::kind_t                     op_kind;
  logic [THREAD_ID_BITS-1:0]           op_tid;
  logic signed [csfq_pkg::COUNT_W-1:0] count, count_next;
  logic [PTR_W-1:0]                    head, head_next, tail, tail_next;
  logic [FILL_W-1:0]                   fill, fill_next;

  csfq_pkg::alu_req_t alu_req;
  csfq_pkg::alu_rsp_t alu_rsp;

  logic                      out_free, step, accept, done, push, pop, clear;
  csfq_pkg::event_t          res_ev;
  csfq_pkg::err_t            res_err;
  logic [THREAD_ID_BITS-1:0] res_id;
  logic                      res_avail, res_last;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  csfq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign step     = (state == ST_EXEC) && out_free;

  assign alu_req.operand = count;
  assign alu_req.inc     = (op_kind == csfq_pkg::KIND_SIGNAL);

  // Decide the outcome of the held item from the count unit's flags.
  always_comb begin
    res_ev     = csfq_pkg::EV_NONE;
    res_err    = csfq_pkg::ERR_NONE;
    res_id     = '0;
    res_avail  = alu_rsp.a_nonneg;
    res_last   = 1'b1;
    done       = 1'b1;
    push       = 1'b0;
    pop        = 1'b0;
    clear      = 1'b0;
    count_next = count;
    case (op_kind)
      csfq_pkg::KIND_WAIT: begin
        if (alu_rsp.at_min) begin
          res_err = csfq_pkg::ERR_SATURATED;
        end else if (alu_rsp.a_le_zero) begin
          if (fill == FILL_FULL) begin
            res_err = csfq_pkg::ERR_QUEUE_FULL;
          end else begin
            count_next = alu_rsp.result;
            push       = 1'b1;
            res_ev     = csfq_pkg::EV_BLOCKED;
            res_avail  = alu_rsp.res_nonneg;
          end
        end else begin
          count_next = alu_rsp.result;
          res_ev     = csfq_pkg::EV_PROCEED;
          res_avail  = alu_rsp.res_nonneg;
        end
      end
      csfq_pkg::KIND_SIGNAL: begin
        if (alu_rsp.at_max) begin
          res_err = csfq_pkg::ERR_SATURATED;
        end else begin
          count_next = alu_rsp.result;
          res_avail  = alu_rsp.res_nonneg;
          if (alu_rsp.res_le_zero && (fill != '0)) begin
            pop    = 1'b1;
            res_ev = csfq_pkg::EV_RELEASED;
            res_id = ram_rd_data;
          end
        end
      end
      csfq_pkg::KIND_CLOSE: begin
        if (fill != '0) begin
          pop      = 1'b1;
          res_ev   = csfq_pkg::EV_RELEASED;
          res_id   = ram_rd_data;
          res_last = (fill == FILL_ONE);
          done     = (fill == FILL_ONE);
          clear    = (fill == FILL_ONE);
        end
      end
      default: begin
      end
    endcase
  end

  // Pointer and fill updates; the RAM reads at the head that will stand next
  // cycle, so the head entry is always ready for one release per unstalled cycle.
  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (step) begin
      if (push) begin
        tail_next = ring_next(tail);
        fill_next = fill + FILL_W'(1);
      end
      if (pop) begin
        head_next = ring_next(head);
        fill_next = fill - FILL_W'(1);
      end
      if (clear) begin
        head_next = '0;
        tail_next = '0;
      end
    end
    if (cfg_wr_en) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end
  end

  assign ram_wr_en   = step && push;
  assign ram_wr_addr = tail;
  assign ram_wr_data = op_tid;
  assign ram_rd_addr = head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
      if (cfg_wr_en) begin
        count <= signed'({1'b0, cfg_wr_data});
      end else if (step) begin
        count <= count_next;
      end
      if (out_valid && !out_stall && !step) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_kind <= csfq_pkg::kind_t'(kind);
            op_tid  <= thread_id;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (step) begin
            out_valid   <= 1'b1;
            event_res   <= res_ev;
            released_id <= res_id;
            available   <= res_avail;
            error       <= res_err;
            last        <= res_last;
            if (done) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("wait queue fill beyond its depth");

  a_empty_ptrs : assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (head == tail))
    else $error("empty wait queue with head and tail apart");

  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted item did not start executing");

  a_release_pops : assert property (@(posedge clk) disable iff (rst)
    (step && (res_ev == csfq_pkg::EV_RELEASED) && !cfg_wr_en)
      |=> (fill == $past(fill) - FILL_W'(1)))
    else $error("release without removing a queue entry");

endmodule

FILE: verif/counting_semaphore_fifo_queue_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the counting semaphore with FIFO wait queue.
// Depends on csfq_pkg and counting_semaphore_fifo_queue_top; an in-bench
// semaphore predictor checks every result item in arrival order.
module counting_semaphore_fifo_queue_top_tb;

  localparam int DEPTH = csfq_pkg::QUEUE_DEPTH_DEF;
  localparam int ID_W = csfq_pkg::THREAD_ID_BITS_DEF;
  localparam int CFG_W = csfq_pkg::CFG_W;
  localparam int COUNT_W = csfq_pkg::COUNT_W;
  localparam int ID_MAX = (1 << ID_W) - 1;
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  // The kind field has a fourth code that the package leaves unnamed.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_GAP = 18;
  localparam int HOLD_CYCLES = 150;
  // Settle time for the sequencer and the output register.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS = 40;
  // Each round of the walk queues a full ring and then closes it, which
  // lowers the count by DEPTH.
  localparam int WALK_ROUNDS = 1;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_t;

  typedef struct packed {
    logic [1:0]      op_kind;
    logic [ID_W-1:0] tid;
  } sem_op_t;

  typedef struct packed {
    csfq_pkg::event_t ev;
    logic [ID_W-1:0]  id;
    logic             avail;
    csfq_pkg::err_t   err;
    logic             last;
  } sem_result_t;

  // Every block input has a known value from time zero.
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       kind = '0;
  logic [ID_W-1:0]  thread_id = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       event_res;
  logic [ID_W-1:0]  released_id;
  logic             available;
  logic [1:0]       error;
  logic             last;

  // Predicted semaphore state: signed count and the ring of blocked ids.
  logic signed [COUNT_W-1:0] sem_count = '0;
  logic [ID_W-1:0]           waiters [DEPTH];
  int                        ring_head = 0;
  int                        ring_tail = 0;
  int                        ring_fill = 0;

  sem_op_t     op_queue[$];
  sem_result_t expected_events[$];

  int ops_queued = 0;
  int ops_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cfg_writes = 0;
  int blocked_cnt = 0;
  int released_cnt = 0;
  int full_cnt = 0;
  int sat_cnt = 0;
  int lowest_count = 0;
  int cycle_cnt = 0;

  idle_mode_t tx_mode = IDLE_FULL;
  idle_mode_t rx_mode = IDLE_FULL;
  int         tx_wait = 0;
  int         rx_wait = 0;
  logic       pressure_on = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;

  counting_semaphore_fifo_queue_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .thread_id   (thread_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .released_id (released_id),
    .available   (available),
    .error       (error),
    .last        (last)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // Number of idle cycles before the next item on one side. Sparse mode is
  // mostly back to back with an occasional long gap.
  function automatic int draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, MAX_GAP)) : 0;
      default:     return $urandom_range(0, MAX_GAP);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom_range(0, ID_MAX));
  endfunction

  // Queue one expected result; available always reflects the count after
  // the step has been applied.
  function automatic void expect_result(csfq_pkg::event_t ev, logic [ID_W-1:0] id,
                                        csfq_pkg::err_t err, logic lst);
    sem_result_t r;
    r.ev = ev;
    r.id = id;
    r.avail = (sem_count >= 0);
    r.err = err;
    r.last = lst;
    expected_events.push_back(r);
    if (ev == csfq_pkg::EV_BLOCKED) blocked_cnt++;
    if (ev == csfq_pkg::EV_RELEASED) released_cnt++;
    if (err == csfq_pkg::ERR_QUEUE_FULL) full_cnt++;
    if (err == csfq_pkg::ERR_SATURATED) sat_cnt++;
  endfunction

  // Semaphore predictor: applies one accepted item to the predicted state and
  // queues the result items it causes.
  function automatic void sem_step(logic [1:0] op, logic [ID_W-1:0] tid);
    logic [ID_W-1:0] rel;
    case (op)
      csfq_pkg::KIND_WAIT: begin
        if (sem_count == csfq_pkg::COUNT_MIN) begin
          // The floor is checked before the queue, so a full queue at the
          // floor still reports saturation.
          expect_result(csfq_pkg::EV_NONE, '0, csfq_pkg::ERR_SATURATED, 1'b1);
        end else if (sem_count <= 0) begin
          if (ring_fill == DEPTH) begin
            expect_result(csfq_pkg::EV_NONE, '0, csfq_pkg::ERR_QUEUE_FULL, 1'b1);
          end else begin
            sem_count = sem_count - COUNT_W'(1);
            waiters[ring_tail] = tid;
            ring_tail = (ring_tail + 1) % DEPTH;
            ring_fill++;
            expect_result(csfq_pkg::EV_BLOCKED, '0, csfq_pkg::ERR_NONE, 1'b1);
          end
        end else begin
          sem_count = sem_count - COUNT_W'(1);
          expect_result(csfq_pkg::EV_PROCEED, '0, csfq_pkg::ERR_NONE, 1'b1);
        end
      end
      csfq_pkg::KIND_SIGNAL: begin
        if (sem_count == csfq_pkg::COUNT_MAX) begin
          expect_result(csfq_pkg::EV_NONE, '0, csfq_pkg::ERR_SATURATED, 1'b1);
        end else begin
          sem_count = sem_count + COUNT_W'(1);
          if (sem_count <= 0 && ring_fill != 0) begin
            rel = waiters[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            ring_fill--;
            expect_result(csfq_pkg::EV_RELEASED, rel, csfq_pkg::ERR_NONE, 1'b1);
          end else begin
            expect_result(csfq_pkg::EV_NONE, '0, csfq_pkg::ERR_NONE, 1'b1);
          end
        end
      end
      csfq_pkg::KIND_CLOSE: begin
        // The count is left alone, even when negative.
        if (ring_fill == 0) expect_result(csfq_pkg::EV_NONE, '0, csfq_pkg::ERR_NONE, 1'b1);
        while (ring_fill != 0) begin
          rel = waiters[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
          expect_result(csfq_pkg::EV_RELEASED, rel, csfq_pkg::ERR_NONE, ring_fill == 0);
        end
        ring_head = 0;
        ring_tail = 0;
      end
      default: expect_result(csfq_pkg::EV_NONE, '0, csfq_pkg::ERR_NONE, 1'b1);
    endcase
    if (int'(sem_count) < lowest_count) lowest_count = int'(sem_count);
  endfunction

  // A register write re-creates the semaphore: new count, empty ring.
  function automatic void load_count(logic [CFG_W-1:0] v);
    sem_count = signed'({1'b0, v});
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result %0d: %s is %0d, expected %0d",
               results_checked, what, got, want);
  endtask

  function automatic void add_op(logic [1:0] k, logic [ID_W-1:0] tid);
    op_queue.push_back('{op_kind: k, tid: tid});
    ops_queued++;
  endfunction

  // Idle means every queued item has been taken and every expected result
  // has arrived; then the block gets SETTLE_CYCLES to settle.
  task automatic wait_idle();
    while (ops_accepted != ops_queued || expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    load_count(v);
    cfg_writes++;
  endtask

  // Random traffic: waits and signals dominate so that the ring fills and
  // drains; closes and the unused kind are the noise.
  task automatic random_ops(int n, int wait_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < wait_pct) add_op(csfq_pkg::KIND_WAIT, rand_id());
      else if (r < 92) add_op(csfq_pkg::KIND_SIGNAL, rand_id());
      else if (r < 97) add_op(csfq_pkg::KIND_CLOSE, rand_id());
      else add_op(KIND_UNUSED, rand_id());
    end
  endtask

  // Sender. The prediction is made at the edge where the item is taken, so
  // the order of expectations follows the order of acceptance. A new item,
  // or the gap before it, starts only once the current one is gone.
  always @(posedge clk) begin : drive_items
    sem_op_t op;
    logic    take;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        sem_step(kind, thread_id);
        ops_accepted++;
      end
      if (!in_valid || take) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          op = op_queue.pop_front();
          in_valid <= 1'b1;
          kind <= op.op_kind;
          thread_id <= op.tid;
          tx_wait <= draw_gap(tx_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each taken result is checked against the oldest expectation,
  // and a fresh stall length is drawn for the next one.
  always @(posedge clk) begin : check_results
    sem_result_t want;
    int          w;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result, event_res", int'(event_res), -1);
        end else begin
          want = expected_events.pop_front();
          if (event_res !== want.ev)
            report_mismatch("event_res", int'(event_res), int'(want.ev));
          if (released_id !== want.id)
            report_mismatch("released_id", int'(released_id), int'(want.id));
          if (available !== want.avail)
            report_mismatch("available", int'(available), int'(want.avail));
          if (error !== want.err)
            report_mismatch("error", int'(error), int'(want.err));
          if (last !== want.last)
            report_mismatch("last", int'(last), int'(want.last));
        end
        results_checked++;
        w = draw_gap(rx_mode);
      end
      rx_wait <= w;
      out_stall <= (w != 0) || (hold_left != 0);
    end
  end

  // Long hold-off, counted here, once: the receiver stops while the sender
  // keeps offering, so the output register fills and the input stalls.
  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done && out_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d items taken of %0d, %0d results pending",
             cycle_cnt, ops_accepted, ops_queued, expected_events.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset count of zero: two waits block, a signal
    // releases the first, a close releases the second as a single-item run,
    // a close on an empty ring, the unused kind, a signal that raises the
    // count to zero with no waiter, then a plain signal and a wait that
    // proceeds.
    add_op(csfq_pkg::KIND_WAIT, 8'h00);
    add_op(csfq_pkg::KIND_WAIT, 8'hFF);
    add_op(csfq_pkg::KIND_SIGNAL, 8'h5A);
    add_op(csfq_pkg::KIND_CLOSE, 8'hA5);
    add_op(csfq_pkg::KIND_CLOSE, 8'h00);
    add_op(KIND_UNUSED, 8'hA5);
    add_op(csfq_pkg::KIND_SIGNAL, 8'hFF);
    add_op(csfq_pkg::KIND_SIGNAL, 8'h0F);
    add_op(csfq_pkg::KIND_WAIT, 8'hF0);

    // Top of the count: signals at the maximum saturate.
    write_count(CFG_W'(CFG_MAX));
    add_op(csfq_pkg::KIND_SIGNAL, 8'h11);
    add_op(csfq_pkg::KIND_WAIT, 8'h22);
    add_op(csfq_pkg::KIND_SIGNAL, 8'h33);
    add_op(csfq_pkg::KIND_SIGNAL, 8'h44);

    // Walk below zero with no idling. The first round tries one wait too
    // many against a full ring.
    write_count('0);
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_NONE;
    for (int r = 0; r < WALK_ROUNDS; r++) begin
      for (int j = 0; j < DEPTH; j++) add_op(csfq_pkg::KIND_WAIT, rand_id());
      if (r == 0) add_op(csfq_pkg::KIND_WAIT, rand_id());
      add_op(csfq_pkg::KIND_CLOSE, rand_id());
    end
    // The ring fills again and a further wait is turned away; a signal frees one
    // slot, a wait takes it back, the next is turned away and a close drains it.
    for (int j = 0; j < DEPTH; j++) add_op(csfq_pkg::KIND_WAIT, rand_id());
    add_op(csfq_pkg::KIND_WAIT, 8'h01);
    add_op(csfq_pkg::KIND_SIGNAL, 8'h02);
    add_op(csfq_pkg::KIND_WAIT, 8'h03);
    add_op(csfq_pkg::KIND_WAIT, 8'h04);
    add_op(csfq_pkg::KIND_CLOSE, 8'h05);
    add_op(csfq_pkg::KIND_WAIT, 8'h06);
    add_op(csfq_pkg::KIND_SIGNAL, 8'h07);

    // Random phases over several count settings and idling patterns.
    write_count('0);
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_FULL;
    random_ops(70, 55);

    write_count(CFG_W'(3));
    tx_mode = IDLE_SPARSE;
    rx_mode = IDLE_FULL;
    random_ops(70, 60);

    write_count(CFG_W'(CFG_MAX));
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_SPARSE;
    random_ops(60, 40);

    write_count(CFG_W'($urandom_range(0, CFG_MAX)));
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_NONE;
    random_ops(60, 50);

    // A count of one with mostly waits keeps the ring near full while the
    // receiver holds off and the sender floods.
    write_count(CFG_W'(1));
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_SPARSE;
    pressure_on <= 1'b1;
    random_ops(55, 65);

    write_count('0);
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_NONE;
    random_ops(55, 50);

    wait_idle();
    $display("Ran %0d items through %0d count settings; %0d results checked, %0d mismatches.",
             ops_accepted, cfg_writes, results_checked, mismatches);
    $display("Seen %0d blocked, %0d released, %0d full-queue rejects, %0d saturations; low %0d.",
             blocked_cnt, released_cnt, full_cnt, sat_cnt, lowest_count);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
